>>> rtl/i2cmbe_pkg.sv
// Shared types, command codes and the control store of the I2C master bit engine.
package i2cmbe_pkg;

    localparam int DEF_NUM_BUSES = 2;
    localparam int UADDR_W       = 5;
    localparam int HOLD_W        = 3;
    localparam int CNT_W         = 3;

    typedef enum logic [2:0] {
        FUNC_START = 3'd0,
        FUNC_STOP  = 3'd1,
        FUNC_WRITE = 3'd2,
        FUNC_READ  = 3'd3,
        FUNC_WACK  = 3'd4,
        FUNC_ACK   = 3'd5,
        FUNC_NACK  = 3'd6,
        FUNC_NONE  = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        SCL_KEEP = 2'd0,
        SCL_LOW  = 2'd1,
        SCL_HIGH = 2'd2
    } t_scl_sel;

    typedef enum logic [1:0] {
        SDA_KEEP = 2'd0,
        SDA_LOW  = 2'd1,
        SDA_HIGH = 2'd2,
        SDA_DATA = 2'd3
    } t_sda_sel;

    typedef struct packed {
        logic [2:0] func;
        logic       bus;
        logic [7:0] data_byte;
        logic [7:0] line_samples;
    } t_in_word;

    typedef struct packed {
        logic              bus_out;
        logic              scl_level;
        logic              sda_level;
        logic [HOLD_W-1:0] hold_units;
        logic              sample_here;
        logic [7:0]        read_byte;
        logic              ack_level;
        logic              last_phase;
    } t_out_word;

    // One control word per pin phase.
    typedef struct packed {
        t_scl_sel           scl_sel;
        t_sda_sel           sda_sel;
        logic [HOLD_W-1:0]  hold;
        logic               sample;
        logic               last;
        logic               shift;
        logic               loop_en;
        logic [CNT_W-1:0]   loop_lim;
        logic [UADDR_W-1:0] loop_tgt;
        logic               res_byte;
        logic               res_ack;
    } t_uword;

    localparam logic [UADDR_W-1:0] UA_START = 5'd0;
    localparam logic [UADDR_W-1:0] UA_STOP  = 5'd4;
    localparam logic [UADDR_W-1:0] UA_WRITE = 5'd7;
    localparam logic [UADDR_W-1:0] UA_READ  = 5'd11;
    localparam logic [UADDR_W-1:0] UA_RLOOP = 5'd12;
    localparam logic [UADDR_W-1:0] UA_WACK  = 5'd18;
    localparam logic [UADDR_W-1:0] UA_ACK   = 5'd22;
    localparam logic [UADDR_W-1:0] UA_NACK  = 5'd26;
    localparam logic [UADDR_W-1:0] UA_LAST  = 5'd28;

    function automatic t_uword uw(t_scl_sel scl, t_sda_sel sda, logic [HOLD_W-1:0] hold,
                                  logic smp, logic last);
        t_uword w;
        w          = '0;
        w.scl_sel  = scl;
        w.sda_sel  = sda;
        w.hold     = hold;
        w.sample   = smp;
        w.last     = last;
        return w;
    endfunction

    function automatic t_uword ucode_rom(logic [UADDR_W-1:0] addr);
        t_uword w;
        case (addr)
            // start
            5'd0:  w = uw(SCL_KEEP, SDA_HIGH, 3'd1, 1'b0, 1'b0);
            5'd1:  w = uw(SCL_HIGH, SDA_HIGH, 3'd4, 1'b0, 1'b0);
            5'd2:  w = uw(SCL_HIGH, SDA_LOW,  3'd4, 1'b0, 1'b0);
            5'd3:  w = uw(SCL_LOW,  SDA_LOW,  3'd1, 1'b0, 1'b1);
            // stop
            5'd4:  w = uw(SCL_KEEP, SDA_LOW,  3'd2, 1'b0, 1'b0);
            5'd5:  w = uw(SCL_HIGH, SDA_LOW,  3'd1, 1'b0, 1'b0);
            5'd6:  w = uw(SCL_HIGH, SDA_HIGH, 3'd2, 1'b0, 1'b1);
            // write byte: eight passes through the bit body, then release SDA
            5'd7:  w = uw(SCL_KEEP, SDA_DATA, 3'd1, 1'b0, 1'b0);
            5'd8:  w = uw(SCL_HIGH, SDA_DATA, 3'd2, 1'b0, 1'b0);
            5'd9: begin
                w          = uw(SCL_LOW, SDA_DATA, 3'd1, 1'b0, 1'b0);
                w.shift    = 1'b1;
                w.loop_en  = 1'b1;
                w.loop_lim = 3'd7;
                w.loop_tgt = UA_WRITE;
            end
            5'd10: w = uw(SCL_LOW,  SDA_HIGH, 3'd0, 1'b0, 1'b1);
            // read byte: seven looped bits, the eighth unrolled with no hold on its final phase
            5'd11: w = uw(SCL_KEEP, SDA_KEEP, 3'd2, 1'b0, 1'b0);
            5'd12: w = uw(SCL_HIGH, SDA_KEEP, 3'd1, 1'b1, 1'b0);
            5'd13: w = uw(SCL_HIGH, SDA_KEEP, 3'd1, 1'b0, 1'b0);
            5'd14: begin
                w          = uw(SCL_LOW, SDA_KEEP, 3'd2, 1'b0, 1'b0);
                w.loop_en  = 1'b1;
                w.loop_lim = 3'd6;
                w.loop_tgt = UA_RLOOP;
            end
            5'd15: w = uw(SCL_HIGH, SDA_KEEP, 3'd1, 1'b1, 1'b0);
            5'd16: w = uw(SCL_HIGH, SDA_KEEP, 3'd1, 1'b0, 1'b0);
            5'd17: begin
                w          = uw(SCL_LOW, SDA_KEEP, 3'd0, 1'b0, 1'b1);
                w.res_byte = 1'b1;
            end
            // wait for acknowledge
            5'd18: w = uw(SCL_KEEP, SDA_HIGH, 3'd2, 1'b0, 1'b0);
            5'd19: w = uw(SCL_HIGH, SDA_HIGH, 3'd1, 1'b1, 1'b0);
            5'd20: w = uw(SCL_HIGH, SDA_HIGH, 3'd1, 1'b0, 1'b0);
            5'd21: begin
                w         = uw(SCL_LOW, SDA_HIGH, 3'd2, 1'b0, 1'b1);
                w.res_ack = 1'b1;
            end
            // acknowledge
            5'd22: w = uw(SCL_KEEP, SDA_LOW,  3'd1, 1'b0, 1'b0);
            5'd23: w = uw(SCL_HIGH, SDA_LOW,  3'd2, 1'b0, 1'b0);
            5'd24: w = uw(SCL_LOW,  SDA_LOW,  3'd2, 1'b0, 1'b0);
            5'd25: w = uw(SCL_LOW,  SDA_HIGH, 3'd0, 1'b0, 1'b1);
            // not-acknowledge
            5'd26: w = uw(SCL_KEEP, SDA_HIGH, 3'd1, 1'b0, 1'b0);
            5'd27: w = uw(SCL_HIGH, SDA_HIGH, 3'd2, 1'b0, 1'b0);
            5'd28: w = uw(SCL_LOW,  SDA_HIGH, 3'd2, 1'b0, 1'b1);
            default: w = uw(SCL_KEEP, SDA_KEEP, 3'd0, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

    function automatic logic [UADDR_W-1:0] entry_addr(logic [2:0] func);
        logic [UADDR_W-1:0] a;
        case (func)
            FUNC_START: a = UA_START;
            FUNC_STOP:  a = UA_STOP;
            FUNC_WRITE: a = UA_WRITE;
            FUNC_READ:  a = UA_READ;
            FUNC_WACK:  a = UA_WACK;
            FUNC_ACK:   a = UA_ACK;
            FUNC_NACK:  a = UA_NACK;
            default:    a = UA_START;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/i2c_master_bit_engine_top.sv
// Top level of the I2C master bit engine: control store sequencer and pin phase output.

// Each accepted command word is expanded into its run of pin phases, one phase per clock
// from a small control store with a step counter and a bit loop: start gives 4 phases,
// stop 3, write byte 25, read byte 25, wait for acknowledge 4, acknowledge 4 and
// not-acknowledge 3. A command is accepted only while the sequencer is idle, before its
// first phase; a command with the code FUNC_NONE or an absent bus is accepted but
// produces nothing. Output back-pressure stalls the sequencer phase by phase. The SCL
// and SDA levels of every bus are held in flops, reset to both lines released high.
module i2c_master_bit_engine_top
    import i2cmbe_pkg::*;
#(
    parameter int NUM_BUSES = DEF_NUM_BUSES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int IDX_W = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;

    logic [1:0]         r_pins [NUM_BUSES];
    logic               r_busy;
    logic [UADDR_W-1:0] r_pc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_bus;
    logic [7:0]         r_data;
    logic [7:0]         r_samples;
    logic               r_out_valid;
    t_out_word          r_out;

    logic               w_in_acc;
    logic               w_cmd_ok;
    logic               w_adv;
    logic [IDX_W-1:0]   w_idx;
    logic [1:0]         w_cur;
    t_uword             w_uw;
    t_out_word          n_out;
    logic [UADDR_W-1:0] n_pc;
    logic [CNT_W-1:0]   n_cnt;

    assign o_in_ready = !r_busy;
    assign w_in_acc   = i_in_valid && !r_busy;
    assign w_cmd_ok   = (i_in_data.func != FUNC_NONE) && (32'(i_in_data.bus) < NUM_BUSES);
    assign w_adv      = r_busy && (!r_out_valid || i_out_ready);
    assign w_idx      = IDX_W'(r_bus);
    assign w_cur      = r_pins[w_idx];
    assign w_uw       = ucode_rom(r_pc);

    always_comb begin
        n_out = '0;
        n_out.bus_out = r_bus;
        case (w_uw.scl_sel)
            SCL_LOW:  n_out.scl_level = 1'b0;
            SCL_HIGH: n_out.scl_level = 1'b1;
            default:  n_out.scl_level = w_cur[1];
        endcase
        case (w_uw.sda_sel)
            SDA_LOW:  n_out.sda_level = 1'b0;
            SDA_HIGH: n_out.sda_level = 1'b1;
            SDA_DATA: n_out.sda_level = r_data[7];
            default:  n_out.sda_level = w_cur[0];
        endcase
        n_out.hold_units  = w_uw.hold;
        n_out.sample_here = w_uw.sample;
        n_out.read_byte   = w_uw.res_byte ? r_samples : 8'd0;
        n_out.ack_level   = w_uw.res_ack & r_samples[7];
        n_out.last_phase  = w_uw.last;
    end

    // The bit loop jumps back until the counter reaches its limit, then falls through.
    always_comb begin
        n_pc  = r_pc + 1'b1;
        n_cnt = r_cnt;
        if (w_uw.loop_en) begin
            if (r_cnt != w_uw.loop_lim) begin
                n_pc  = w_uw.loop_tgt;
                n_cnt = r_cnt + 1'b1;
            end else begin
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_cnt       <= '0;
            for (int i = 0; i < NUM_BUSES; i++) begin
                r_pins[i] <= 2'b11;
            end
        end else begin
            if (w_in_acc) begin
                r_busy <= w_cmd_ok;
                r_pc   <= entry_addr(i_in_data.func);
                r_cnt  <= '0;
            end else if (w_adv) begin
                r_pc      <= n_pc;
                r_cnt     <= n_cnt;
                r_busy    <= !w_uw.last;
                r_pins[w_idx] <= {n_out.scl_level, n_out.sda_level};
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_bus     <= i_in_data.bus;
            r_data    <= i_in_data.data_byte;
            r_samples <= i_in_data.line_samples;
        end else if (w_adv && w_uw.shift) begin
            r_data <= {r_data[6:0], 1'b0};
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_uw.last) |=> !r_busy)
        else $error("sequencer still busy after the final phase");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= UA_LAST))
        else $error("step counter outside the control store");

    a_bad_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_cmd_ok) |=> (!r_busy && !$rose(r_out_valid)))
        else $error("ignored command started a phase run");

    a_result_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_phase) |->
            (r_out.read_byte == 8'd0 && r_out.ack_level == 1'b0))
        else $error("result fields set on a phase that is not the last");

endmodule
